// File: hdl/hzsb_pkg.sv
// ----------------------------------------------------------------------------
// Register hazard scoreboard package
// Shared types, codes and constants for the scoreboard and its tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package hzsb_pkg;

    // Default sizes
    localparam int NUM_REGS_DEF = 32;
    localparam int TAG_BITS_DEF = 8;

    // Fixed field widths
    localparam int REG_W   = 5;
    localparam int TAG_W   = 8;
    localparam int ENC_W   = 3;
    localparam int KIND_W  = 3;

    // Float register ranges scanned by the custom kinds (low, high exclusive)
    localparam int SCAN_BOX_LO   = 0;
    localparam int SCAN_BOX_HI   = 12;
    localparam int SCAN_TRI_LO   = 0;
    localparam int SCAN_TRI_HI   = 18;
    localparam int SCAN_LBRAY_LO = 0;
    localparam int SCAN_LBRAY_HI = 8;
    localparam int SCAN_SBRAY_LO = 0;
    localparam int SCAN_SBRAY_HI = 6;
    localparam int SCAN_CSHIT_LO = 15;
    localparam int SCAN_CSHIT_HI = 19;

    typedef enum logic {
        REQ_ISSUE = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req;

    typedef enum logic [ENC_W-1:0] {
        ENC_R    = 3'd0,
        ENC_R4   = 3'd1,
        ENC_I    = 3'd2,
        ENC_S    = 3'd3,
        ENC_B    = 3'd4,
        ENC_U    = 3'd5,
        ENC_J    = 3'd6,
        ENC_NONE = 3'd7
    } t_enc;

    typedef enum logic [KIND_W-1:0] {
        CK_NONE     = 3'd0,
        CK_BOXISECT = 3'd1,
        CK_TRIISECT = 3'd2,
        CK_LBRAY    = 3'd3,
        CK_SBRAY    = 3'd4,
        CK_CSHIT    = 3'd5
    } t_kind;

    // Read request into the tag store
    typedef struct packed {
        logic             dst_float;
        logic             src_float;
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0] rd;
        logic [REG_W-1:0] rs1;
        logic [REG_W-1:0] rs2;
        logic [REG_W-1:0] rs3;
    } t_rd_req;

    // Tags returned by the tag store, zero-extended to the field width
    typedef struct packed {
        logic [TAG_W-1:0] dst_rd;
        logic [TAG_W-1:0] dst_rs2;
        logic [TAG_W-1:0] src_rs1;
        logic [TAG_W-1:0] src_rs2;
        logic [TAG_W-1:0] src_rs3;
        logic [TAG_W-1:0] scan;
    } t_rd_rsp;

    // Write into the tag store
    typedef struct packed {
        logic             en;
        logic             is_float;
        logic [REG_W-1:0] idx;
        logic [TAG_W-1:0] tag;
    } t_wr_req;

    // True if float register idx lies in the range that a custom kind scans
    function automatic logic scan_in_range(input logic [KIND_W-1:0] kind, input int idx);
        logic hit;
        hit = 1'b0;
        case (kind)
            CK_BOXISECT: hit = (idx >= SCAN_BOX_LO)   && (idx < SCAN_BOX_HI);
            CK_TRIISECT: hit = (idx >= SCAN_TRI_LO)   && (idx < SCAN_TRI_HI);
            CK_LBRAY:    hit = (idx >= SCAN_LBRAY_LO) && (idx < SCAN_LBRAY_HI);
            CK_SBRAY:    hit = (idx >= SCAN_SBRAY_LO) && (idx < SCAN_SBRAY_HI);
            CK_CSHIT:    hit = (idx >= SCAN_CSHIT_LO) && (idx < SCAN_CSHIT_HI);
            default:     hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

// File: hdl/register_hazard_scoreboard.sv
// ----------------------------------------------------------------------------
// Register hazard scoreboard
// Tracks pending producers for 32 integer and 32 float registers, checks
// each issue for hazards and marks the destination of a stall-free writer pending.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------------
//  request   i_valid / o_ready    i_req_type .. i_type_tag
//  result    o_valid / i_ready    o_stall_res, o_blocking_tag
//
//  One request is taken every cycle unless a held result fills the input
//  register; each result passes the input register, then the result register.
//  The hazard check, custom range scan and tag update sit combinationally
//  between those registers, so the next request sees the updated tags.
//  A held result holds the input register; o_ready drops while that register
//  is full behind it and rises again in the cycle that the result transfers.
//  Synchronous reset frees every register and empties both stages.
//
`default_nettype none

module register_hazard_scoreboard
    import hzsb_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_req_type,
    input  wire logic [ENC_W-1:0] i_encoding,
    input  wire logic [KIND_W-1:0] i_custom_kind,
    input  wire logic [REG_W-1:0] i_rd,
    input  wire logic [REG_W-1:0] i_rs1,
    input  wire logic [REG_W-1:0] i_rs2,
    input  wire logic [REG_W-1:0] i_rs3,
    input  wire logic             i_dst_float,
    input  wire logic             i_src_float,
    input  wire logic [TAG_W-1:0] i_type_tag,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_stall_res,
    output logic [TAG_W-1:0]      o_blocking_tag
);

    // Input register
    logic             r_in_vld;
    t_req             r_req;
    t_enc             r_enc;
    logic [TAG_W-1:0] r_tag;
    t_rd_req          r_rd_req;

    // Result register
    logic             r_out_vld;
    logic             r_stall;
    logic [TAG_W-1:0] r_blk;

    logic             w_adv;
    t_rd_rsp          w_rsp;
    t_wr_req          w_wr;
    logic [TAG_W-1:0] n_blk_enc;
    logic             n_wr_rd;
    logic [TAG_W-1:0] n_blk;

    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;

    // Capture a request on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req              <= t_req'(i_req_type);
            r_enc              <= t_enc'(i_encoding);
            r_tag              <= i_type_tag;
            r_rd_req.dst_float <= i_dst_float;
            r_rd_req.src_float <= i_src_float;
            r_rd_req.kind      <= i_custom_kind;
            r_rd_req.rd        <= i_rd;
            r_rd_req.rs1       <= i_rs1;
            r_rd_req.rs2       <= i_rs2;
            r_rd_req.rs3       <= i_rs3;
        end
    end

    hzsb_tags #(
        .NUM_REGS (NUM_REGS),
        .TAG_BITS (TAG_BITS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (r_rd_req),
        .o_rd    (w_rsp),
        .i_wr    (w_wr)
    );

    // Check the registers that the encoding uses, in order
    always_comb begin
        n_blk_enc = '0;
        n_wr_rd   = 1'b0;
        unique case (r_enc)
            ENC_R: begin
                n_blk_enc = (w_rsp.dst_rd  != '0) ? w_rsp.dst_rd  :
                            (w_rsp.src_rs1 != '0) ? w_rsp.src_rs1 : w_rsp.src_rs2;
                n_wr_rd   = 1'b1;
            end
            ENC_R4: begin
                n_blk_enc = (w_rsp.dst_rd  != '0) ? w_rsp.dst_rd  :
                            (w_rsp.src_rs1 != '0) ? w_rsp.src_rs1 :
                            (w_rsp.src_rs2 != '0) ? w_rsp.src_rs2 : w_rsp.src_rs3;
                n_wr_rd   = 1'b1;
            end
            ENC_I: begin
                n_blk_enc = (w_rsp.dst_rd != '0) ? w_rsp.dst_rd : w_rsp.src_rs1;
                n_wr_rd   = 1'b1;
            end
            ENC_S: begin
                n_blk_enc = (w_rsp.dst_rs2 != '0) ? w_rsp.dst_rs2 : w_rsp.src_rs1;
            end
            ENC_B: begin
                n_blk_enc = (w_rsp.src_rs1 != '0) ? w_rsp.src_rs1 : w_rsp.src_rs2;
            end
            ENC_U, ENC_J: begin
                n_blk_enc = w_rsp.dst_rd;
                n_wr_rd   = 1'b1;
            end
            ENC_NONE: begin
                n_blk_enc = '0;
            end
        endcase
    end

    // Resolve the result and the tag update; the custom scan wins
    always_comb begin
        w_wr.is_float = r_rd_req.dst_float;
        w_wr.idx      = r_rd_req.rd;
        if (r_req == REQ_CLEAR) begin
            n_blk   = '0;
            w_wr.en = w_adv;
            w_wr.tag = '0;
        end else begin
            n_blk    = (w_rsp.scan != '0) ? w_rsp.scan : n_blk_enc;
            w_wr.en  = w_adv && (n_blk == '0) && n_wr_rd;
            w_wr.tag = r_tag;
        end
    end

    // Hold the result until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_stall <= (n_blk != '0);
            r_blk   <= n_blk;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_stall_res    = r_stall;
    assign o_blocking_tag = r_blk;

endmodule

`default_nettype wire

// File: hdl/hzsb_tags.sv
// ----------------------------------------------------------------------------
// Scoreboard tag store
// Pending tags for the integer and float register files, with parallel
// read ports, the custom range scan and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module hzsb_tags
    import hzsb_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_rd_req i_rd,
    output t_rd_rsp      o_rd,
    input  wire t_wr_req i_wr
);

    localparam int IDX_W = $clog2(NUM_REGS);

    logic [TAG_BITS-1:0] r_int_tags [NUM_REGS];
    logic [TAG_BITS-1:0] r_flt_tags [NUM_REGS];

    logic [IDX_W-1:0] w_idx;
    logic [TAG_W-1:0] n_scan;

    assign w_idx = i_wr.idx[IDX_W-1:0];

    // Update one entry; integer register zero stays free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_int_tags[i] <= '0;
                r_flt_tags[i] <= '0;
            end
        end else if (i_wr.en) begin
            if (i_wr.is_float) begin
                r_flt_tags[w_idx] <= i_wr.tag[TAG_BITS-1:0];
            end else if (w_idx != '0) begin
                r_int_tags[w_idx] <= i_wr.tag[TAG_BITS-1:0];
            end
        end
    end

    // Pick the lowest-index pending float register in the custom range
    always_comb begin
        n_scan = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (scan_in_range(i_rd.kind, i) && (r_flt_tags[i] != '0)) begin
                n_scan = TAG_W'(r_flt_tags[i]);
            end
        end
    end

    // Read the operand tags from the selected files
    always_comb begin
        o_rd.dst_rd  = i_rd.dst_float ? TAG_W'(r_flt_tags[i_rd.rd[IDX_W-1:0]])
                                      : TAG_W'(r_int_tags[i_rd.rd[IDX_W-1:0]]);
        o_rd.dst_rs2 = i_rd.dst_float ? TAG_W'(r_flt_tags[i_rd.rs2[IDX_W-1:0]])
                                      : TAG_W'(r_int_tags[i_rd.rs2[IDX_W-1:0]]);
        o_rd.src_rs1 = i_rd.src_float ? TAG_W'(r_flt_tags[i_rd.rs1[IDX_W-1:0]])
                                      : TAG_W'(r_int_tags[i_rd.rs1[IDX_W-1:0]]);
        o_rd.src_rs2 = i_rd.src_float ? TAG_W'(r_flt_tags[i_rd.rs2[IDX_W-1:0]])
                                      : TAG_W'(r_int_tags[i_rd.rs2[IDX_W-1:0]]);
        o_rd.src_rs3 = i_rd.src_float ? TAG_W'(r_flt_tags[i_rd.rs3[IDX_W-1:0]])
                                      : TAG_W'(r_int_tags[i_rd.rs3[IDX_W-1:0]]);
        o_rd.scan    = n_scan;
    end

endmodule

`default_nettype wire

// File: hdl/hzsb_checker.sv
// ----------------------------------------------------------------------------
// Scoreboard port checker
// Watches the scoreboard ports for result consistency, latency and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hzsb_checker
    import hzsb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic             o_stall_res,
    input wire logic [TAG_W-1:0] o_blocking_tag
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_stall_res)
                                   && $stable(o_blocking_tag)))
        else $error("result changed while stalled");

    // Stall flag agrees with the blocking tag
    a_stall_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_stall_res == (o_blocking_tag != '0)))
        else $error("stall flag and blocking tag disagree");

    // A fresh result follows an earlier request transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result without a matching request");

    // No result straight out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind register_hazard_scoreboard hzsb_checker u_hzsb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_stall_res    (o_stall_res),
    .o_blocking_tag (o_blocking_tag)
);

`default_nettype wire

// File: bench/register_hazard_scoreboard_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Register hazard scoreboard testbench
// Feeds directed and random issue and clear requests through the request
// channel, predicts each verdict from a private copy of the tag store and
// checks every verdict on the result channel, in order, field by field.
// ----------------------------------------------------------------------------

module register_hazard_scoreboard_tb;

    import hzsb_pkg::*;

    localparam int                 TAG_BITS   = TAG_BITS_DEF;
    localparam logic [TAG_W-1:0]   TAG_MASK   = TAG_W'((1 << TAG_BITS) - 1);
    localparam int                 RAND_ITEMS = 1000;
    localparam int                 STUCK_MAX  = 2000;
    localparam int                 CALM_FIRST = 400;
    localparam int                 CALM_LAST  = 560;
    localparam int                 REPORT_MAX = 40;

    typedef struct packed {
        t_req              req;
        t_enc              enc;
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rs1;
        logic [REG_W-1:0]  rs2;
        logic [REG_W-1:0]  rs3;
        logic              dst_float;
        logic              src_float;
        logic [TAG_W-1:0]  tag;
    } t_request;

    typedef struct packed {
        logic             stall;
        logic [TAG_W-1:0] blocker;
    } t_verdict;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_ready;
    logic              i_req_type     = 1'b0;
    logic [ENC_W-1:0]  i_encoding     = '0;
    logic [KIND_W-1:0] i_custom_kind  = '0;
    logic [REG_W-1:0]  i_rd           = '0;
    logic [REG_W-1:0]  i_rs1          = '0;
    logic [REG_W-1:0]  i_rs2          = '0;
    logic [REG_W-1:0]  i_rs3          = '0;
    logic              i_dst_float    = 1'b0;
    logic              i_src_float    = 1'b0;
    logic [TAG_W-1:0]  i_type_tag     = '0;
    logic              o_valid;
    logic              i_ready        = 1'b0;
    logic              o_stall_res;
    logic [TAG_W-1:0]  o_blocking_tag;

    // Private copy of the pending tags
    logic [TAG_W-1:0]  int_tags [NUM_REGS_DEF];
    logic [TAG_W-1:0]  flt_tags [NUM_REGS_DEF];

    t_request          request_backlog [$];
    t_verdict          verdicts_due [$];
    t_request          held_request;
    int                accepted_count = 0;
    int                mismatch_count = 0;
    int                stuck_cycles   = 0;
    logic              calm;

    register_hazard_scoreboard #(
        .NUM_REGS (NUM_REGS_DEF),
        .TAG_BITS (TAG_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_encoding     (i_encoding),
        .i_custom_kind  (i_custom_kind),
        .i_rd           (i_rd),
        .i_rs1          (i_rs1),
        .i_rs2          (i_rs2),
        .i_rs3          (i_rs3),
        .i_dst_float    (i_dst_float),
        .i_src_float    (i_src_float),
        .i_type_tag     (i_type_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stall_res    (o_stall_res),
        .o_blocking_tag (o_blocking_tag)
    );

    always #10 i_clk = ~i_clk;

    // No idling on either side over a stretch of the run
    assign calm = (accepted_count >= CALM_FIRST) && (accepted_count < CALM_LAST);

    function automatic logic [TAG_W-1:0] read_tag(input logic is_float,
                                                   input logic [REG_W-1:0] idx);
        return is_float ? flt_tags[idx] : int_tags[idx];
    endfunction

    // Integer register zero never holds a producer
    function automatic void write_tag(input logic is_float, input logic [REG_W-1:0] idx,
                                      input logic [TAG_W-1:0] value);
        if (is_float) begin
            flt_tags[idx] = value;
        end else if (idx != '0) begin
            int_tags[idx] = value;
        end
    endfunction

    function automatic logic [TAG_W-1:0] first_set(input logic [TAG_W-1:0] a,
                                                   input logic [TAG_W-1:0] b);
        return (a != '0) ? a : b;
    endfunction

    // Lowest pending float register in the window of a custom kind
    function automatic logic [TAG_W-1:0] range_scan(input logic [KIND_W-1:0] kind);
        int               lo;
        int               hi;
        logic [TAG_W-1:0] hit;
        lo  = 0;
        hi  = 0;
        hit = '0;
        case (kind)
            CK_BOXISECT: begin lo = SCAN_BOX_LO;   hi = SCAN_BOX_HI;   end
            CK_TRIISECT: begin lo = SCAN_TRI_LO;   hi = SCAN_TRI_HI;   end
            CK_LBRAY:    begin lo = SCAN_LBRAY_LO; hi = SCAN_LBRAY_HI; end
            CK_SBRAY:    begin lo = SCAN_SBRAY_LO; hi = SCAN_SBRAY_HI; end
            CK_CSHIT:    begin lo = SCAN_CSHIT_LO; hi = SCAN_CSHIT_HI; end
            default:     begin lo = 0;             hi = 0;             end
        endcase
        for (int i = lo; i < hi; i++) begin
            if (hit == '0 && flt_tags[i] != '0) begin
                hit = flt_tags[i];
            end
        end
        return hit;
    endfunction

    // Work out the verdict of one request and update the tag copy
    function automatic t_verdict hazard_verdict(input t_request r);
        t_verdict         v;
        logic [TAG_W-1:0] d_rd;
        logic [TAG_W-1:0] d_rs2;
        logic [TAG_W-1:0] s_rs1;
        logic [TAG_W-1:0] s_rs2;
        logic [TAG_W-1:0] s_rs3;
        logic [TAG_W-1:0] blk;
        logic             marks;
        v     = '0;
        marks = 1'b0;
        d_rd  = read_tag(r.dst_float, r.rd);
        d_rs2 = read_tag(r.dst_float, r.rs2);
        s_rs1 = read_tag(r.src_float, r.rs1);
        s_rs2 = read_tag(r.src_float, r.rs2);
        s_rs3 = read_tag(r.src_float, r.rs3);
        if (r.req == REQ_CLEAR) begin
            write_tag(r.dst_float, r.rd, '0);
            return v;
        end
        blk = range_scan(r.kind);
        if (blk == '0) begin
            case (r.enc)
                ENC_R:  begin blk = first_set(first_set(d_rd, s_rs1), s_rs2); marks = 1'b1; end
                ENC_R4: begin
                    blk   = first_set(first_set(first_set(d_rd, s_rs1), s_rs2), s_rs3);
                    marks = 1'b1;
                end
                ENC_I:  begin blk = first_set(d_rd, s_rs1); marks = 1'b1; end
                ENC_S:  blk = first_set(d_rs2, s_rs1);
                ENC_B:  blk = first_set(s_rs1, s_rs2);
                ENC_U, ENC_J: begin blk = d_rd; marks = 1'b1; end
                default: blk = '0;
            endcase
            // A stalled issue leaves the tags alone
            if (blk == '0 && marks) begin
                write_tag(r.dst_float, r.rd, r.tag & TAG_MASK);
            end
        end
        v.stall   = (blk != '0);
        v.blocker = blk;
        return v;
    endfunction

    function automatic t_request make_request(input t_req req, input t_enc enc,
                                              input logic [KIND_W-1:0] kind,
                                              input logic [REG_W-1:0] rd,
                                              input logic [REG_W-1:0] rs1,
                                              input logic [REG_W-1:0] rs2,
                                              input logic [REG_W-1:0] rs3,
                                              input logic dstf, input logic srcf,
                                              input logic [TAG_W-1:0] tag);
        t_request r;
        r.req       = req;
        r.enc       = enc;
        r.kind      = kind;
        r.rd        = rd;
        r.rs1       = rs1;
        r.rs2       = rs2;
        r.rs3       = rs3;
        r.dst_float = dstf;
        r.src_float = srcf;
        r.tag       = tag;
        return r;
    endfunction

    // Favour the low registers so that hazards and scan hits are common
    function automatic logic [REG_W-1:0] reg_pick();
        if ($urandom_range(1) == 1) begin
            return REG_W'($urandom_range(31));
        end
        return REG_W'($urandom_range(7));
    endfunction

    // Present requests; predict each one as it transfers
    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                verdicts_due.push_back(hazard_verdict(held_request));
                accepted_count <= accepted_count + 1;
            end
            if (request_backlog.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
                nxt            = request_backlog.pop_front();
                held_request   = nxt;
                i_valid       <= 1'b1;
                i_req_type    <= nxt.req;
                i_encoding    <= nxt.enc;
                i_custom_kind <= nxt.kind;
                i_rd          <= nxt.rd;
                i_rs1         <= nxt.rs1;
                i_rs2         <= nxt.rs2;
                i_rs3         <= nxt.rs3;
                i_dst_float   <= nxt.dst_float;
                i_src_float   <= nxt.src_float;
                i_type_tag    <= nxt.tag;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Take verdicts and compare them with the oldest prediction
    always @(posedge i_clk) begin : watch_verdicts
        t_verdict want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (verdicts_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("%0t: verdict with none due: stall %0d tag %0h",
                                 $time, o_stall_res, o_blocking_tag);
                    end
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_stall_res !== want.stall) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("%0t: stall_res expected %0d actual %0d",
                                     $time, want.stall, o_stall_res);
                        end
                    end
                    if (o_blocking_tag !== want.blocker) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("%0t: blocking_tag expected %0h actual %0h",
                                     $time, want.blocker, o_blocking_tag);
                        end
                    end
                end
            end
            i_ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles + 1 >= STUCK_MAX) begin
                $display("register_hazard_scoreboard: mismatch");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin
        t_request r;
        for (int i = 0; i < NUM_REGS_DEF; i++) begin
            int_tags[i] = '0;
            flt_tags[i] = '0;
        end

        // Directed: every encoding, every custom kind, integer zero,
        // zero tag, stalls and clears
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_R, CK_NONE, 5, 0, 31, 0,
                                               0, 0, 8'hFF));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_I, CK_NONE, 6, 5, 0, 0,
                                               0, 0, 8'h11));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_R4, CK_NONE, 31, 0, 0, 0,
                                               1, 1, 8'h01));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_R4, CK_NONE, 1, 2, 4, 31,
                                               1, 1, 8'h22));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_U, CK_NONE, 0, 0, 0, 0,
                                               0, 0, 8'hAA));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_B, CK_NONE, 0, 0, 0, 0,
                                               0, 0, 8'h12));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_J, CK_NONE, 16, 0, 0, 0,
                                               1, 0, 8'h5A));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_NONE, CK_CSHIT, 0, 0, 0, 0,
                                               0, 0, 8'h13));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_NONE, CK_BOXISECT, 0, 0, 0, 0,
                                               0, 0, 8'h14));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_U, CK_NONE, 3, 0, 0, 0,
                                               1, 0, 8'h33));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_U, CK_NONE, 10, 0, 0, 0,
                                               1, 0, 8'h44));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_NONE, CK_SBRAY, 0, 0, 0, 0,
                                               0, 0, 8'h15));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_NONE, CK_TRIISECT, 0, 0, 0, 0,
                                               0, 0, 8'h16));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_NONE, CK_LBRAY, 0, 0, 0, 0,
                                               0, 0, 8'h17));
        // Unused custom kinds behave as none
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_NONE, 3'd6, 0, 0, 0, 0,
                                               0, 0, 8'h18));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_U, 3'd7, 20, 0, 0, 0,
                                               1, 0, 8'h77));
        // Store data register sits in the destination file
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_S, CK_NONE, 0, 0, 3, 0,
                                               1, 0, 8'h19));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_S, CK_NONE, 7, 8, 7, 0,
                                               0, 0, 8'h1A));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_I, CK_NONE, 7, 8, 0, 0,
                                               0, 0, 8'h09));
        // Zero tag leaves the register free
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_U, CK_NONE, 9, 0, 0, 0,
                                               0, 0, 8'h00));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_B, CK_NONE, 0, 9, 7, 0,
                                               0, 0, 8'h1B));
        request_backlog.push_back(make_request(REQ_CLEAR, ENC_R, CK_TRIISECT, 3, 31, 31, 31,
                                               1, 0, 8'hFF));
        request_backlog.push_back(make_request(REQ_ISSUE, ENC_NONE, CK_SBRAY, 0, 0, 0, 0,
                                               0, 0, 8'h1C));
        request_backlog.push_back(make_request(REQ_CLEAR, ENC_NONE, CK_NONE, 5, 0, 0, 0,
                                               0, 1, 8'h00));
        request_backlog.push_back(make_request(REQ_CLEAR, ENC_J, CK_CSHIT, 16, 0, 0, 0,
                                               1, 1, 8'h80));

        // Random: issues mixed with enough clears to keep registers cycling
        for (int n = 0; n < RAND_ITEMS; n++) begin
            r.req       = ($urandom_range(99) < 35) ? REQ_CLEAR : REQ_ISSUE;
            r.enc       = t_enc'($urandom_range(7));
            r.kind      = ($urandom_range(99) < 25) ? KIND_W'($urandom_range(1, 7)) : CK_NONE;
            r.rd        = reg_pick();
            r.rs1       = reg_pick();
            r.rs2       = reg_pick();
            r.rs3       = reg_pick();
            r.dst_float = 1'($urandom_range(1));
            r.src_float = 1'($urandom_range(1));
            r.tag       = ($urandom_range(99) < 5) ? '0 : TAG_W'($urandom_range(1, 255));
            request_backlog.push_back(r);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests sent, all verdicts back, then a short settle
        while (request_backlog.size() != 0 || i_valid) @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("register_hazard_scoreboard: match");
        end else begin
            $display("register_hazard_scoreboard: mismatch");
        end
        $finish;
    end

endmodule
